// File: sv/rgbconv_pkg.sv
`timescale 1ns / 1ps
package rgbconv_pkg;

  localparam int NUM_REGS = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;
  localparam int COEF_W = 16;
  localparam int PROD_W = 25;
  localparam int ACC_W = 29;
  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_TOP    = 2'd0,
    REG_COEF_MIDDLE = 2'd1,
    REG_COEF_BOTTOM = 2'd2,
    REG_IMAGE_WIDTH = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ROWS_NONE = 2'd0,
    ROWS_ONE  = 2'd1,
    ROWS_TWO  = 2'd2
  } rows_e;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] pix_t;

  // [row][col], row 0 top, col 0 left
  typedef pix_t [2:0][2:0] win_t;

  typedef logic signed [COEF_W-1:0] coef_word_t;
  typedef coef_word_t [2:0][2:0] coef_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  typedef struct packed {
    logic       action;
    logic       frame_start;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
    logic       last_of_run;
  } out_t;

endpackage

// File: sv/rgbconv_cfg.sv
`timescale 1ns / 1ps
module rgbconv_cfg import rgbconv_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output coef_t                 coef_o,
  output logic [CW-1:0]         last_col_o
);

  localparam int RstWidth = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam logic [CW-1:0] RstLastCol = CW'(RstWidth - 1);

  coef_t         coef_q;
  logic [CW-1:0] last_col_q;
  logic [CW-1:0] last_col_d;
  int            raw_w;

  // width clamped to 2..MAX_WIDTH, kept as width minus one
  always_comb begin
    raw_w = int'(cfg_wdata_i[10:0]);
    if (raw_w < 2) begin
      last_col_d = CW'(1);
    end else if (raw_w > MAX_WIDTH) begin
      last_col_d = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_d = CW'(raw_w - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q     <= {{CFG_DATA_W{1'b0}}, 48'd256, {CFG_DATA_W{1'b0}}};
      last_col_q <= RstLastCol;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_COEF_TOP:    coef_q[0] <= cfg_wdata_i;
        REG_COEF_MIDDLE: coef_q[1] <= cfg_wdata_i;
        REG_COEF_BOTTOM: coef_q[2] <= cfg_wdata_i;
        REG_IMAGE_WIDTH: last_col_q <= last_col_d;
        default: ;
      endcase
    end
  end

  assign coef_o     = coef_q;
  assign last_col_o = last_col_q;

endmodule

// File: sv/rgbconv_linebuf.sv
`timescale 1ns / 1ps
module rgbconv_linebuf import rgbconv_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [CW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [CW-1:0] wr_addr_i,
  input  line_t         wr_data_i,
  output line_t         rd_data_o
);

  line_t mem [MAX_WIDTH];
  line_t rd_q;
  line_t fwd_data_q;
  logic  fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // same-address write in the read cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// File: sv/rgbconv_filter.sv
`timescale 1ns / 1ps
module rgbconv_filter import rgbconv_pkg::*; #(
  parameter int COEF_FRAC_BITS = 8
) (
  input  win_t  win_i,
  input  coef_t coef_i,
  output pix_t  pix_o
);

  always_comb begin
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  scaled;
    for (int ch = 0; ch < 3; ch++) begin
      acc = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod = $signed({1'b0, win_i[r][c][ch]}) * coef_i[r][c];
          acc  = acc + ACC_W'(prod);
        end
      end
      scaled = acc >>> COEF_FRAC_BITS;
      if (acc[ACC_W-1]) begin
        pix_o[ch] = 8'd0;
      end else if (scaled > ACC_W'(PIX_MAX)) begin
        pix_o[ch] = PIX_MAX;
      end else begin
        pix_o[ch] = scaled[7:0];
      end
    end
  end

endmodule

// File: sv/rgb_convolution_3x3_mirror_edge_unit.sv
`timescale 1ns / 1ps
// 3x3 convolution of an RGB raster stream with edge-repeating borders. One item is
// taken per clock while in_stall_o is low; an item at the last column of a row
// after the first gives two results, so it stalls the input side while the
// single result register drains them. An accepted item passes through the line
// store read and first-stage registers, then the window register, and then the
// 27-tap filter loads the output register. Both line stores share one MAX_WIDTH
// x 48 bit memory, read at accept and written as a non-flush item moves into the
// window. Output row r comes out while input row r+1 arrives; a pass of
// image_width flush items drives out the last row.
module rgb_convolution_3x3_mirror_edge_unit import rgbconv_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  coef_t         coef;
  logic [CW-1:0] last_col;

  logic [CW-1:0] col_q;
  rows_e         rows_q;
  logic [CW-1:0] col_cur;
  rows_e         rows_cur;
  logic          row_done;
  logic          in_acc;

  logic          s1_vld_q;
  logic          s1_action_q;
  pix_t          s1_pix_q;
  logic          s1_first_q;
  logic          s1_e1_q;
  logic          s1_e2_q;
  logic          s1_two_q;
  logic [CW-1:0] s1_addr_q;
  logic          s1_adv;

  line_t         rd_line;
  line_t         wr_line;
  pix_t          top;
  pix_t          mid;
  pix_t          bot;

  logic          pend1_q;
  logic          pend2_q;
  logic          emit;
  logic          s2_free;

  win_t          win_q;
  win_t          filt_win;
  pix_t          filt_pix;

  logic          out_valid_q;
  out_t          out_q;

  rgbconv_cfg #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef),
    .last_col_o (last_col)
  );

  // input side
  assign in_acc   = in_valid_i && !in_stall_o;
  assign col_cur  = in_data_i.frame_start ? '0 : col_q;
  assign rows_cur = in_data_i.frame_start ? ROWS_NONE : rows_q;
  assign row_done = col_cur >= last_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rows_q <= ROWS_NONE;
    end else if (in_acc) begin
      if (row_done) begin
        col_q <= '0;
        if (in_data_i.action) begin
          rows_q <= ROWS_NONE;
        end else if (rows_cur == ROWS_NONE) begin
          rows_q <= ROWS_ONE;
        end else begin
          rows_q <= ROWS_TWO;
        end
      end else begin
        col_q  <= col_cur + CW'(1);
        rows_q <= rows_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= in_data_i.action;
      s1_pix_q    <= {in_data_i.pixel_blue, in_data_i.pixel_green, in_data_i.pixel_red};
      s1_first_q  <= col_cur == '0;
      s1_e1_q     <= (rows_cur != ROWS_NONE) && (col_cur != '0);
      s1_e2_q     <= (rows_cur != ROWS_NONE) && row_done;
      s1_two_q    <= rows_cur == ROWS_TWO;
      s1_addr_q   <= col_cur;
    end
  end

  rgbconv_linebuf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_linebuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc),
    .rd_addr_i(col_cur),
    .wr_en_i  (s1_adv && !s1_action_q),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(wr_line),
    .rd_data_o(rd_line)
  );

  // window column from the line stores and the input pixel
  assign mid           = rd_line.newer;
  assign top           = s1_two_q ? rd_line.older : mid;
  assign bot           = s1_action_q ? mid : s1_pix_q;
  assign wr_line.older = mid;
  assign wr_line.newer = s1_pix_q;

  // emit stage
  assign emit    = (pend1_q || pend2_q) && (!out_valid_q || !out_stall_i);
  assign s2_free = !(pend1_q || pend2_q) || (emit && !(pend1_q && pend2_q));
  assign s1_adv  = s1_vld_q && s2_free;
  assign in_stall_o = s1_vld_q && !s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend1_q <= 1'b0;
      pend2_q <= 1'b0;
    end else begin
      if (emit) begin
        if (pend1_q) begin
          pend1_q <= 1'b0;
        end else begin
          pend2_q <= 1'b0;
        end
      end
      if (s1_adv) begin
        pend1_q <= s1_e1_q;
        pend2_q <= s1_e2_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      if (s1_first_q) begin
        win_q[0] <= {3{top}};
        win_q[1] <= {3{mid}};
        win_q[2] <= {3{bot}};
      end else begin
        win_q[0] <= {top, win_q[0][2], win_q[0][1]};
        win_q[1] <= {mid, win_q[1][2], win_q[1][1]};
        win_q[2] <= {bot, win_q[2][2], win_q[2][1]};
      end
    end
  end

  // row end result repeats the right column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (pend1_q) begin
        filt_win[r] = win_q[r];
      end else begin
        filt_win[r] = {win_q[r][2], win_q[r][2], win_q[r][1]};
      end
    end
  end

  rgbconv_filter #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_filter (
    .win_i (filt_win),
    .coef_i(coef),
    .pix_o (filt_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_red     <= filt_pix[0];
      out_q.out_green   <= filt_pix[1];
      out_q.out_blue    <= filt_pix[2];
      out_q.row_end     <= !pend1_q;
      out_q.last_of_run <= !(pend1_q && pend2_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
